[design/velocity_rescale_thermostat_macros.svh]
// Assertion macros for the velocity rescale thermostat.
`ifndef VELOCITY_RESCALE_THERMOSTAT_MACROS_SVH
`define VELOCITY_RESCALE_THERMOSTAT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define VRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

[design/vrt_pkg.sv]
// Package: widths, constants and shared types of the thermostat.
package vrt_pkg;
  localparam int VelBits = 32;
  localparam logic [16:0] FactorOne = 17'd65536;
  localparam logic [16:0] FactorMax = 17'd78643;
  localparam logic [16:0] FactorMin = 17'd52429;
  localparam logic [1:0] CfgEnabled = 2'd0;
  localparam logic [1:0] CfgTarget  = 2'd1;
  localparam logic [1:0] CfgCoupling = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_VEL, CMD_PASS, CMD_REP_START, CMD_REP_OFF, CMD_DIV, CMD_TERM, CMD_SQRT,
    CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    load;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
  } dp_stat_t;
endpackage

[design/vrt_datapath.sv]
// Datapath: divider, multiply, square root and velocity scaling.
module vrt_datapath import vrt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [23:0]         target_temp,
  input  logic [23:0]         coupling,
  input  logic [23:0]         temp_in,
  input  logic [23:0]         freedom_in,
  input  logic [VelBits-1:0]  vel_in,
  input  logic                last_in,
  output logic [VelBits-1:0]  vel_out,
  output logic [16:0]         factor,
  output logic                done_out
);
  logic [16:0] factor_r, factor_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [47:0] num_r, num_nxt;
  logic [23:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;
  logic        neg_r, neg_nxt;
  logic [33:0] sx_r, sx_nxt;
  logic [33:0] sres_r, sres_nxt;
  logic [33:0] sbit_r, sbit_nxt;
  logic [71:0] acc_r, acc_nxt;
  logic [VelBits-1:0] vout_r, vout_nxt;
  logic        done_r, done_nxt;

  logic [24:0] rem_sh;
  logic [47:0] dmag;
  logic [55:0] term;
  logic        term_big;
  logic [34:0] t1;
  logic [16:0] lam;
  logic        vneg;
  logic [VelBits-1:0] vmag;
  logic [VelBits+16:0] vprod;
  logic [VelBits+16:0] vrnd;
  logic [VelBits-1:0] half;

  always_comb begin
    rem_sh = {rem_r[23:0], num_r[47]};
    dmag = (quo_r < 48'h1000000) ? (48'h1000000 - quo_r) : (quo_r - 48'h1000000);
    term = acc_r[71:16];
    term_big = |term[55:32];
    t1 = 35'(sres_r) + 35'(sbit_r);
    lam = (sres_r[16:0] == 17'd0) ? FactorOne :
          (sres_r > 34'(FactorMax)) ? FactorMax :
          (sres_r < 34'(FactorMin)) ? FactorMin : sres_r[16:0];
    half = {1'b1, {(VelBits-1){1'b0}}};
    vneg = vel_in[VelBits-1];
    vmag = vneg ? (~vel_in + 1'b1) : vel_in;
    vprod = (VelBits+17)'(vmag) * (VelBits+17)'(factor_r);
    vrnd = (vprod + (VelBits+17)'(17'h8000)) >> 16;
  end

  always_comb begin
    factor_nxt = factor_r; quo_nxt = quo_r; rem_nxt = rem_r; num_nxt = num_r;
    den_nxt = den_r; cnt_nxt = cnt_r; skip_nxt = skip_r; neg_nxt = neg_r;
    sx_nxt = sx_r; sres_nxt = sres_r; sbit_nxt = sbit_r;
    acc_nxt = acc_r; vout_nxt = vout_r; done_nxt = done_r;
    stat.step_last = 1'b0;
    unique case (cmd.op)
      CMD_VEL: begin
        if (vneg) vout_nxt = (vrnd > (VelBits+17)'(half)) ? half : ~vrnd[VelBits-1:0] + 1'b1;
        else vout_nxt = (vrnd > (VelBits+17)'(half - 1'b1)) ? half - 1'b1 : vrnd[VelBits-1:0];
        done_nxt = last_in;
      end
      CMD_PASS: begin
        vout_nxt = vel_in; done_nxt = last_in;
      end
      CMD_REP_OFF: begin
        vout_nxt = '0; done_nxt = 1'b0;
      end
      CMD_REP_START: begin
        factor_nxt = FactorOne;
        vout_nxt = '0; done_nxt = 1'b0;
        skip_nxt = (temp_in == 24'd0) || (freedom_in == 24'd0) || (target_temp == 24'd0);
        num_nxt = {target_temp, 24'd0}; den_nxt = temp_in;
        rem_nxt = '0; quo_nxt = '0; cnt_nxt = 6'd47;
      end
      CMD_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r}; quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = rem_sh; quo_nxt = {quo_r[46:0], 1'b0};
        end
        num_nxt = {num_r[46:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        stat.step_last = (cnt_r == 6'd0);
        if (cnt_r == 6'd0) begin
          acc_nxt = '0; cnt_nxt = 6'd2;
        end
      end
      CMD_TERM: begin
        // two partial products: low 24 bits of dmag, then high part; then root operand
        if (cnt_r == 6'd2) begin
          acc_nxt = 72'(48'(coupling) * 48'(dmag[23:0]));
          neg_nxt = quo_r < 48'h1000000;
        end else if (cnt_r == 6'd1) begin
          acc_nxt = acc_r + (72'(48'(coupling) * 48'(dmag[47:24])) << 24);
        end
        cnt_nxt = cnt_r - 6'd1;
        stat.step_last = (cnt_r == 6'd0);
        if (cnt_r == 6'd0) begin
          if (neg_r) begin
            skip_nxt = skip_r || term_big;
            sx_nxt = 34'h100000000 - 34'(term[31:0]);
          end else begin
            sx_nxt = term_big ? 34'h200000000 : 34'h100000000 + 34'(term[31:0]);
          end
          sres_nxt = '0; sbit_nxt = 34'h100000000; cnt_nxt = 6'd16;
        end
      end
      CMD_SQRT: begin
        if (35'(sx_r) >= t1) begin
          sx_nxt = 34'(35'(sx_r) - t1); sres_nxt = (sres_r >> 1) + sbit_r;
        end else sres_nxt = sres_r >> 1;
        sbit_nxt = sbit_r >> 2;
        cnt_nxt = cnt_r - 6'd1;
        stat.step_last = (cnt_r == 6'd0);
      end
      CMD_FINISH: begin
        if (!skip_r && quo_r != 48'd0) factor_nxt = lam;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) factor_r <= FactorOne;
    else factor_r <= factor_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; num_r <= num_nxt; den_r <= den_nxt;
    cnt_r <= cnt_nxt; skip_r <= skip_nxt; neg_r <= neg_nxt;
    sx_r <= sx_nxt; sres_r <= sres_nxt; sbit_r <= sbit_nxt; acc_r <= acc_nxt;
    vout_r <= vout_nxt; done_r <= done_nxt;
  end

  assign vel_out = vout_r;
  assign factor = factor_r;
  assign done_out = done_r;
  logic unused_ok;
  assign unused_ok = cmd.load;
endmodule

[design/vrt_ctrl.sv]
// Controller: sequences reports and velocity requests, holds the output handshake.
module vrt_ctrl import vrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     req_vel,
  input  logic     enabled,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
`include "velocity_rescale_thermostat_macros.svh"
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_TERM, S_SQRT, S_FIN} state_t;
  state_t state_r;
  logic   out_valid_r;
  logic   take;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.op = CMD_NONE; cmd.load = take;
    unique case (state_r)
      S_IDLE: if (take) begin
        if (req_vel) cmd.op = enabled ? CMD_VEL : CMD_PASS;
        else cmd.op = enabled ? CMD_REP_START : CMD_REP_OFF;
      end
      S_DIV:  cmd.op = CMD_DIV;
      S_TERM: cmd.op = CMD_TERM;
      S_SQRT: cmd.op = CMD_SQRT;
      S_FIN:  cmd.op = CMD_FINISH;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (take) begin
          if (req_vel) out_valid_r <= 1'b1;
          else if (enabled) state_r <= S_DIV;
          else out_valid_r <= 1'b1;
        end
        S_DIV:  if (stat.step_last) state_r <= S_TERM;
        S_TERM: if (stat.step_last) state_r <= S_SQRT;
        S_SQRT: if (stat.step_last) state_r <= S_FIN;
        S_FIN: begin
          state_r <= S_IDLE; out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VRT_ASSERT_IMP(a_busy_no_ready, state_r != S_IDLE, !in_ready)
  `VRT_ASSERT_NXT(a_fin_valid, state_r == S_FIN, out_valid_r)
  `VRT_ASSERT_IMP(a_busy_no_out, (state_r == S_DIV) || (state_r == S_SQRT), !out_valid_r)
endmodule

[design/velocity_rescale_thermostat.sv]
// Top level: Berendsen-style velocity rescaling thermostat.
// channel  | ports       | contents
// in       | in_t*       | request: report or velocity component
// out      | out_t*      | one result per request
// cfg      | cfg_*       | register writes, no read-back
// Velocity request: result registered in the cycle after accept.
// Enabled report: steps are start, divide, multiply, root, finish.
// Disabled report: factor unchanged.
// A request is taken only when the output register is empty or drains that cycle.
// Synchronous active-low reset; factor resets to one.
module velocity_rescale_thermostat import vrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // temperature, freedom, velocity_in, zero fill
  input  logic        in_tuser,  // req_type
  input  logic        in_tlast,  // last_in_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // velocity_out, scale_factor, zero fill
  output logic        out_tlast, // frame_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic        enabled_r;
  logic [23:0] target_r, coupling_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [VelBits-1:0] vel_out;
  logic [16:0] factor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0; target_r <= 24'd76800; coupling_r <= 24'd16777;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgEnabled:  enabled_r <= cfg_data[0];
        CfgTarget:   target_r <= cfg_data;
        CfgCoupling: coupling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vrt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .req_vel(in_tuser),
    .enabled(enabled_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .cmd, .stat
  );

  vrt_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .target_temp(target_r), .coupling(coupling_r),
    .temp_in(in_tdata[23:0]), .freedom_in(in_tdata[47:24]),
    .vel_in(in_tdata[79:48]), .last_in(in_tlast),
    .vel_out, .factor, .done_out(out_tlast)
  );

  assign out_tdata = {7'd0, factor, vel_out};
  logic unused_ok;
  assign unused_ok = ^in_tdata[87:80];
endmodule
